>>> rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the stable priority queue.
// Used by spq_cell, stable_priority_queue and spq_checker; no dependencies.
package spq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned PRIO_W       = 32;
  localparam int unsigned OCC_W        = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } spq_kind_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  // One stored entry as it moves along the chain.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_entry_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_cmd_t;

endpackage

>>> rtl/spq_cell.sv
// spq_cell: one slot of the sorted shift-register queue.
// Depends on spq_pkg (entry and command structs).
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_entry_t left_i,      // neighbor closer to the head
  input  logic                left_keep_i, // neighbor keeps its entry on insert
  input  spq_pkg::spq_entry_t right_i,     // neighbor closer to the tail
  output spq_pkg::spq_entry_t ent_o,
  output logic                keep_o
);

  spq_pkg::spq_entry_t ent_d, ent_q;

  // Stored entry stays ahead of a new one with equal or lower priority.
  assign keep_o = ent_q.valid && ($signed(ent_q.prio) >= $signed(cmd_i.prio));

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          ent_d.valid = 1'b1;
          ent_d.prio  = cmd_i.prio;
          ent_d.data  = cmd_i.data;
        end else begin
          ent_d = left_i;
        end
      end
    end else if (cmd_i.rem) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

>>> rtl/stable_priority_queue.sv
// Stable priority queue: a row of spq_cell slots kept sorted, highest priority first,
// equal priorities in arrival order. Takes one transaction per cycle: busy_o stays low,
// every accepted transaction (start_i high, busy_o low) gives its result with done_o
// in the next cycle, driven for a single cycle with no way to hold it off. All slots
// compare against the new priority at once and shift by one in that same cycle.
// Depends on spq_pkg and spq_cell.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [spq_pkg::DATA_W-1:0]  data_in_i,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_in_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [spq_pkg::DATA_W-1:0]  data_out_o,
  output logic [spq_pkg::PRIO_W-1:0]  priority_out_o,
  output logic [spq_pkg::OCC_W-1:0]   occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                accept;
  logic                full;
  logic                empty;
  spq_pkg::spq_cmd_t   cmd;
  spq_pkg::spq_entry_t ent   [CAPACITY];
  logic                keep  [CAPACITY];

  logic [CntW-1:0]              count_d, count_q;
  logic                         done_q;
  spq_pkg::spq_status_e         status_d, status_q;
  logic [spq_pkg::DATA_W-1:0]   dout_d, dout_q;
  logic [spq_pkg::PRIO_W-1:0]   pout_d, pout_q;
  logic [spq_pkg::OCC_W-1:0]    occ_q;

  // Every transaction's result is registered in the cycle after it is accepted, so no back-pressure is needed.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);

  assign cmd.ins  = accept && (kind_i == spq_pkg::KIND_INSERT) && !full;
  assign cmd.rem  = accept && (kind_i == spq_pkg::KIND_REMOVE) && !empty;
  assign cmd.prio = priority_in_i;
  assign cmd.data = data_in_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::spq_entry_t left_ent, right_ent;
    logic                left_keep;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_ent),
      .left_keep_i (left_keep),
      .right_i     (right_ent),
      .ent_o       (ent[i]),
      .keep_o      (keep[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_INSERTED;
    dout_d   = '0;
    pout_d   = '0;
    if (kind_i == spq_pkg::KIND_INSERT) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d  = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        status_d = spq_pkg::ST_REMOVED;
        dout_d   = ent[0].data;
        pout_d   = ent[0].prio;
        count_d  = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      dout_q   <= dout_d;
      pout_q   <= pout_d;
      occ_q    <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign data_out_o     = dout_q;
  assign priority_out_o = pout_q;
  assign occupancy_o    = occ_q;

endmodule

>>> rtl/spq_checker.sv
// spq_checker: port-level assertions for stable_priority_queue, bound to the top level.
// Depends on spq_pkg (status codes, field widths).
module spq_checker #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       kind_i,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [spq_pkg::DATA_W-1:0] data_out_o,
  input logic [spq_pkg::PRIO_W-1:0] priority_out_o,
  input logic [spq_pkg::OCC_W-1:0]  occupancy_o
);

  // Each transaction gives exactly one result in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without a transaction");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != spq_pkg::ST_REMOVED)) |->
      ((data_out_o == '0) && (priority_out_o == '0)))
    else $error("payload not zero on non-remove result");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == spq_pkg::ST_EMPTY)) |-> (occupancy_o == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == spq_pkg::ST_FULL)) |->
      (occupancy_o == spq_pkg::OCC_W'(CAPACITY)))
    else $error("full status with wrong occupancy");

endmodule

bind stable_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .kind_i         (kind_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .data_out_o     (data_out_o),
  .priority_out_o (priority_out_o),
  .occupancy_o    (occupancy_o)
);
